// ----- hw/rtl/nsc_pkg.sv -----
// nsc_pkg: shared widths, codes and item types for the nearest-site classifier.
// No dependencies; imported by nsc_cell and nearest_site_classifier_core.
package nsc_pkg;

  localparam int DEF_MAX_SITES = 16;
  localparam int CFG_W         = 5;
  localparam int COORD_W       = 16;
  localparam int DIFF_W        = COORD_W + 1;
  localparam int SQ_W          = 2 * COORD_W;
  localparam int DIST_W        = SQ_W + 2;
  localparam int SLOT_MAX_W    = 8;   // enough for the largest table
  localparam int CELL_DEPTH    = 4;   // diff, square, sum, compare

  // 3 * 65535^2, the largest squared distance two points can have
  localparam logic [DIST_W-1:0] DIST_MAX = 34'd12884508675;

  typedef enum logic {
    REQ_LOAD     = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_t;

  // item moving down the cell chain
  typedef struct packed {
    logic                  valid;
    req_t                  req;
    logic [SLOT_MAX_W-1:0] slot;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic [COORD_W-1:0]    z;
    logic                  last;
  } item_t;

  // running best match, skewed CELL_DEPTH stages behind the item
  typedef struct packed {
    logic                  valid;
    logic                  last;
    logic [SLOT_MAX_W-1:0] idx;
    logic [DIST_W-1:0]     dist_sq;
  } best_t;

endpackage

// ----- hw/rtl/nsc_cell.sv -----
// nsc_cell: one site of the systolic chain; holds the site and a four-stage
// distance/compare pipeline. Depends on nsc_pkg.
module nsc_cell import nsc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  active,
  input  item_t item_in,
  output item_t item_out,
  input  best_t best_in,
  output best_t best_out
);

  localparam logic [SLOT_MAX_W-1:0] SLOT_IDX = SLOT_MAX_W'(IDX);
  localparam bit FIRST = (IDX == 0);

  item_t                     item_q;
  logic [COORD_W-1:0]        site_x, site_y, site_z;
  logic signed [DIFF_W-1:0]  dx, dy, dz;
  logic signed [DIFF_W-1:0]  dx_next, dy_next, dz_next;
  logic signed [2*DIFF_W-1:0] px, py, pz;
  logic [SQ_W-1:0]           sq_x, sq_y, sq_z;
  logic [DIST_W-1:0]         dist_sum;
  logic                      take;
  best_t                     best_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q.valid <= 1'b0;
    end else if (adv) begin
      item_q <= item_in;
    end
  end

  // a load writes the site as it passes, so earlier points see the old site
  always_ff @(posedge clk) begin
    if (adv && item_q.valid && item_q.req == REQ_LOAD && item_q.slot == SLOT_IDX) begin
      site_x <= item_q.x;
      site_y <= item_q.y;
      site_z <= item_q.z;
    end
  end

  assign dx_next = $signed({item_q.x[COORD_W-1], item_q.x}) - $signed({site_x[COORD_W-1], site_x});
  assign dy_next = $signed({item_q.y[COORD_W-1], item_q.y}) - $signed({site_y[COORD_W-1], site_y});
  assign dz_next = $signed({item_q.z[COORD_W-1], item_q.z}) - $signed({site_z[COORD_W-1], site_z});

  assign px = dx * dx;
  assign py = dy * dy;
  assign pz = dz * dz;

  // squares of a 17-bit difference fit in 32 bits
  always_ff @(posedge clk) begin
    if (adv) begin
      dx       <= dx_next;
      dy       <= dy_next;
      dz       <= dz_next;
      sq_x     <= px[SQ_W-1:0];
      sq_y     <= py[SQ_W-1:0];
      sq_z     <= pz[SQ_W-1:0];
      dist_sum <= DIST_W'(sq_x) + DIST_W'(sq_y) + DIST_W'(sq_z);
    end
  end

  // strict compare keeps the lowest index on ties
  assign take = FIRST || (active && (dist_sum < best_in.dist_sq));

  always_ff @(posedge clk) begin
    if (rst) begin
      best_q.valid <= 1'b0;
    end else if (adv) begin
      best_q.valid   <= best_in.valid;
      best_q.last    <= best_in.last;
      best_q.idx     <= take ? SLOT_IDX : best_in.idx;
      best_q.dist_sq <= take ? dist_sum : best_in.dist_sq;
    end
  end

  assign item_out = item_q;
  assign best_out = best_q;

endmodule

// ----- hw/rtl/nearest_site_classifier_core.sv -----
// nearest_site_classifier_core: top level, a chain of nsc_cell instances, one
// per site, plus the count register and the seed of the best-match chain.
// Depends on nsc_pkg and nsc_cell.
//
//   channel  signals                              direction  note
//   config   cfg_wr_en, cfg_wr_data               in         num_sites, no read-back
//   request  in_valid/in_stall, req_type..last    in         load site or classify
//   result   out_valid/out_stall, nearest_site..  out        one per classify item
//
// One item per cycle unless a stalled result holds the chain; a classify result
// is produced by the chain of one cell per site, four stages per cell.
// Reset clears all valid bits and sets num_sites to 1; the site table is
// left unwritten. A stalled result freezes the whole chain, input included.
module nearest_site_classifier_core import nsc_pkg::*; #(
  parameter int MAX_SITES = DEF_MAX_SITES,
  localparam int SLOT_W = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [CFG_W-1:0]   cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               req_type,
  input  logic [SLOT_W-1:0]  site_slot,
  input  logic [COORD_W-1:0] coord_x,
  input  logic [COORD_W-1:0] coord_y,
  input  logic [COORD_W-1:0] coord_z,
  input  logic               last_point,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SLOT_W-1:0]  nearest_site,
  output logic [DIST_W-1:0]  nearest_dist_sq,
  output logic               last_out
);

  logic [CFG_W-1:0]   num_sites;
  logic               adv;
  logic [MAX_SITES-1:0] act;
  item_t              item_c [MAX_SITES];
  best_t              best_c [MAX_SITES+1];
  best_t              seed   [CELL_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      num_sites <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      num_sites <= cfg_wr_data;
    end
  end

  assign adv      = !(best_c[MAX_SITES].valid && out_stall);
  assign in_stall = !adv;

  always_comb begin
    item_c[0].valid = in_valid;
    item_c[0].req   = req_t'(req_type);
    item_c[0].slot  = SLOT_MAX_W'(site_slot);
    item_c[0].x     = coord_x;
    item_c[0].y     = coord_y;
    item_c[0].z     = coord_z;
    item_c[0].last  = last_point;
  end

  // seed travels alongside cell 0's pipeline; cell 0 always takes its own site
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CELL_DEPTH; i++) begin
        seed[i].valid <= 1'b0;
      end
    end else if (adv) begin
      seed[0].valid   <= in_valid && (req_t'(req_type) == REQ_CLASSIFY);
      seed[0].last    <= last_point;
      seed[0].idx     <= '0;
      seed[0].dist_sq <= DIST_MAX;
      for (int i = 1; i < CELL_DEPTH; i++) begin
        seed[i] <= seed[i-1];
      end
    end
  end

  assign best_c[0] = seed[CELL_DEPTH-1];

  // site j is searched when j < num_sites; site 0 always
  for (genvar g = 0; g < MAX_SITES; g++) begin : g_cell
    assign act[g] = (32'(num_sites) > 32'(g));
    if (g < MAX_SITES - 1) begin : g_mid
      nsc_cell #(.IDX(g)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .adv      (adv),
        .active   (act[g]),
        .item_in  (item_c[g]),
        .item_out (item_c[g+1]),
        .best_in  (best_c[g]),
        .best_out (best_c[g+1])
      );
    end else begin : g_end
      nsc_cell #(.IDX(g)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .adv      (adv),
        .active   (act[g]),
        .item_in  (item_c[g]),
        .item_out (),
        .best_in  (best_c[g]),
        .best_out (best_c[g+1])
      );
    end
  end

  assign out_valid       = best_c[MAX_SITES].valid;
  assign nearest_site    = best_c[MAX_SITES].idx[SLOT_W-1:0];
  assign nearest_dist_sq = best_c[MAX_SITES].dist_sq;
  assign last_out        = best_c[MAX_SITES].last;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_index_in_table: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(best_c[MAX_SITES].idx) < 32'(MAX_SITES)))
    else $error("nearest site index beyond table");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (nearest_dist_sq <= DIST_MAX))
    else $error("distance above largest possible value");

endmodule
